// ===== hdl/bhc_pkg.sv =====
package bhc_pkg;

    localparam int BOUNDARY_DEF    = 30;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int WIN             = 6;
    localparam int HEX_BITS        = 12;
    localparam int TBL_SEL_BITS    = 3;
    localparam int ADDR_BITS       = TBL_SEL_BITS + HEX_BITS;
    localparam int TABLE_DEPTH     = 6 * (1 << HEX_BITS);
    localparam int SEEN_BITS       = 7;
    localparam int OUT_WIDTH       = 32;

    localparam logic [1:0] ACT_BASE  = 2'd0;
    localparam logic [1:0] ACT_LAST  = 2'd1;
    localparam logic [1:0] ACT_RDCNT = 2'd2;
    localparam logic [1:0] ACT_RDTOT = 2'd3;

    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_STOP     = 2'd1;
    localparam logic [1:0] REG_INTERIOR = 2'd2;

    localparam logic [2:0] BASE_INVALID = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                 clr_we;     // clear one table entry (clr_addr)
        logic [ADDR_BITS-1:0] clr_addr;
        logic                 shift;      // push input base into history
        logic                 upd_rd;     // read table for a window update
        logic                 upd_src;    // 0: recent history, 1: leading bases
        logic [5:0]           upd_pos;    // window position
        logic [1:0]           upd_region;
        logic                 upd_strand;
        logic                 upd_wb;     // write back the increment read last cycle
        logic                 rd_req;     // read for a user query
        logic                 rd_out;     // capture query data into output reg
        logic                 seen_clr;
    } bhc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [SEEN_BITS-1:0] seen;
        logic                 win_ok;     // selected window is all ACGT
    } bhc_sts_t;

endpackage

// ===== hdl/bhc_ctrl.sv =====
module bhc_ctrl #(
    parameter int BOUNDARY = bhc_pkg::BOUNDARY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_action,
    input  logic                       out_busy,
    output logic                       out_load,
    output bhc_pkg::bhc_cmd_t          cmd,
    input  bhc_pkg::bhc_sts_t          sts
);

    localparam int NWIN     = BOUNDARY - bhc_pkg::WIN + 1;
    localparam int INT_MIN  = 2 * BOUNDARY + bhc_pkg::WIN - 1;
    localparam int MIN_GENE = 60;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INT   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [bhc_pkg::ADDR_BITS:0] clr_reg, clr_next;
    logic [5:0] pos_reg, pos_next;
    logic       strand_reg, strand_next;
    logic       phase_reg, phase_next;       // 0 start windows, 1 stop windows
    logic       last_reg, last_next;
    logic [2:0] ret_reg, ret_next;
    logic       accept;
    logic [bhc_pkg::SEEN_BITS-1:0] seen_after;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_busy;
    assign seen_after = (sts.seen == '1) ? sts.seen : sts.seen + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        strand_next = strand_reg;
        phase_next  = phase_reg;
        last_next   = last_reg;
        ret_next    = ret_reg;
        cmd         = '0;
        out_load    = 1'b0;
        cmd.clr_addr   = clr_reg[bhc_pkg::ADDR_BITS-1:0];
        cmd.upd_pos    = pos_reg;
        cmd.upd_strand = strand_reg;
        cmd.upd_src    = phase_reg ? 1'b0 : 1'b1;
        cmd.upd_region = phase_reg ? bhc_pkg::REG_STOP : bhc_pkg::REG_START;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == (bhc_pkg::ADDR_BITS+1)'(bhc_pkg::TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == bhc_pkg::ACT_BASE || in_action == bhc_pkg::ACT_LAST)
                    begin
                        cmd.shift   = 1'b1;
                        last_next   = (in_action == bhc_pkg::ACT_LAST);
                        strand_next = 1'b0;
                        if (32'(sts.seen) >= INT_MIN)
                            state_next = S_INT;
                        else if (in_action == bhc_pkg::ACT_LAST)
                        begin
                            if (32'(seen_after) >= MIN_GENE)
                            begin
                                state_next = S_FLUSH;
                                pos_next   = '0;
                                phase_next = 1'b0;
                            end
                            else
                                cmd.seen_clr = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.rd_req = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_INT:
            begin
                cmd.upd_src    = 1'b0;
                cmd.upd_region = bhc_pkg::REG_INTERIOR;
                cmd.upd_pos    = 6'(BOUNDARY);
                cmd.upd_rd     = sts.win_ok;
                ret_next       = S_INT;
                if (sts.win_ok)
                    state_next = S_WB;
                if (!sts.win_ok)
                begin
                    strand_next = 1'b0;
                    if (last_reg)
                    begin
                        if (32'(sts.seen) >= MIN_GENE)
                        begin
                            state_next = S_FLUSH;
                            pos_next   = '0;
                            phase_next = 1'b0;
                        end
                        else
                        begin
                            cmd.seen_clr = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.upd_rd = sts.win_ok;
                ret_next   = S_FLUSH;
                if (sts.win_ok)
                    state_next = S_WB;
                else
                begin
                    strand_next = 1'b0;
                    if (pos_reg == 6'(NWIN - 1))
                    begin
                        pos_next = '0;
                        if (phase_reg)
                        begin
                            cmd.seen_clr = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                            phase_next = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            S_WB:
            begin
                cmd.upd_wb = 1'b1;
                state_next = ret_reg;
                if (!strand_reg)
                    strand_next = 1'b1;
                else
                begin
                    strand_next = 1'b0;
                    if (ret_reg == S_INT)
                    begin
                        if (last_reg && 32'(sts.seen) >= MIN_GENE)
                        begin
                            state_next = S_FLUSH;
                            pos_next   = '0;
                            phase_next = 1'b0;
                        end
                        else
                        begin
                            cmd.seen_clr = last_reg;
                            state_next   = S_IDLE;
                        end
                    end
                    else if (pos_reg == 6'(NWIN - 1))
                    begin
                        pos_next = '0;
                        if (phase_reg)
                        begin
                            cmd.seen_clr = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                            phase_next = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd_out = 1'b1;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pos_reg    <= '0;
            strand_reg <= 1'b0;
            phase_reg  <= 1'b0;
            last_reg   <= 1'b0;
            ret_reg    <= S_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pos_reg    <= pos_next;
            strand_reg <= strand_next;
            phase_reg  <= phase_next;
            last_reg   <= last_next;
            ret_reg    <= ret_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> $past(cmd.upd_rd)) else $error("write back without read");
    a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_req |=> out_load) else $error("query not answered");

endmodule

// ===== hdl/bhc_dpath.sv =====
module bhc_dpath #(
    parameter int BOUNDARY    = bhc_pkg::BOUNDARY_DEF,
    parameter int COUNT_WIDTH = bhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bhc_pkg::bhc_cmd_t         cmd,
    output bhc_pkg::bhc_sts_t         sts,
    input  logic [2:0]                in_base,
    input  logic [1:0]                in_action,
    input  logic [1:0]                in_region,
    input  logic                      in_strand,
    input  logic [bhc_pkg::HEX_BITS-1:0] in_hexamer,
    output logic [bhc_pkg::OUT_WIDTH-1:0] rd_count
);

    localparam int DEPTH = BOUNDARY + bhc_pkg::WIN;
    localparam int AW    = bhc_pkg::ADDR_BITS;
    localparam int LW    = $clog2(BOUNDARY);
    localparam int RW    = $clog2(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [COUNT_WIDTH-1:0] mem [bhc_pkg::TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] mem_q;
    logic [COUNT_WIDTH-1:0] tot_reg [6];
    logic [2:0] recent_reg [DEPTH];
    logic [2:0] lead_reg [BOUNDARY];
    logic [bhc_pkg::SEEN_BITS-1:0] seen_reg;
    logic [2:0] w [bhc_pkg::WIN];
    logic [2*bhc_pkg::WIN-1:0] fwd, rev;
    logic ok;
    logic [2:0] tsel;
    logic [AW-1:0] upd_addr, wb_addr_reg;
    logic [2:0] wb_sel_reg;
    logic q_tot_reg, q_bad_reg;
    logic [2:0] q_sel_reg;
    logic [COUNT_WIDTH-1:0] qv;

    always_comb
    begin
        for (int j = 0; j < bhc_pkg::WIN; j++)
            w[j] = cmd.upd_src ? lead_reg[LW'(7'(cmd.upd_pos) + 7'(j))]
                               : recent_reg[RW'(7'(cmd.upd_pos) + 7'(bhc_pkg::WIN - 1 - j))];
        ok  = 1'b1;
        fwd = '0;
        rev = '0;
        for (int j = 0; j < bhc_pkg::WIN; j++)
        begin
            ok  = ok && !w[j][2];
            fwd = {fwd[2*bhc_pkg::WIN-3:0], w[j][1:0]};
            rev = {rev[2*bhc_pkg::WIN-3:0], ~w[bhc_pkg::WIN-1-j][1:0]};
        end
    end

    assign tsel     = {cmd.upd_region, cmd.upd_strand};
    assign upd_addr = {tsel, cmd.upd_strand ? rev : fwd};
    assign sts      = '{seen: seen_reg, win_ok: ok};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
            mem[cmd.clr_addr] <= '0;
        else if (cmd.upd_wb)
            mem[wb_addr_reg] <= (mem_q == CMAX) ? mem_q : mem_q + 1'b1;
        if (cmd.upd_rd)
            mem_q <= mem[upd_addr];
        else if (cmd.rd_req)
            mem_q <= mem[{in_region, in_strand, in_hexamer}];
        if (cmd.upd_rd)
        begin
            wb_addr_reg <= upd_addr;
            wb_sel_reg  <= tsel;
        end
        if (cmd.rd_req)
        begin
            q_tot_reg <= (in_action == bhc_pkg::ACT_RDTOT);
            q_bad_reg <= (in_region > bhc_pkg::REG_INTERIOR);
            q_sel_reg <= {in_region, in_strand};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                tot_reg[i] <= '0;
            for (int i = 0; i < DEPTH; i++)
                recent_reg[i] <= bhc_pkg::BASE_INVALID;
            seen_reg <= '0;
        end
        else
        begin
            if (cmd.upd_wb && tot_reg[wb_sel_reg] != CMAX)
                tot_reg[wb_sel_reg] <= tot_reg[wb_sel_reg] + 1'b1;
            if (cmd.shift)
            begin
                recent_reg[0] <= in_base;
                for (int i = 1; i < DEPTH; i++)
                    recent_reg[i] <= recent_reg[i-1];
            end
            // gene end clears the count even on the base that ends it
            if (cmd.seen_clr)
                seen_reg <= '0;
            else if (cmd.shift && seen_reg != '1)
                seen_reg <= seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift && 32'(seen_reg) < BOUNDARY)
            lead_reg[seen_reg[LW-1:0]] <= in_base;
    end

    always_comb
    begin
        qv = q_tot_reg ? tot_reg[q_sel_reg] : mem_q;
        if (q_bad_reg)
            rd_count = '0;
        else if (COUNT_WIDTH > bhc_pkg::OUT_WIDTH && (qv >> bhc_pkg::OUT_WIDTH) != '0)
            rd_count = '1;
        else
            rd_count = bhc_pkg::OUT_WIDTH'(qv);
    end

    a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_wb |-> $past(cmd.upd_rd)) else $error("write back without read");
    a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_we |-> !cmd.shift && !cmd.upd_rd && !cmd.rd_req) else $error("clear overlap");
    a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.shift && !cmd.seen_clr) |=> $stable(seen_reg)) else $error("seen moved");

endmodule

// ===== hdl/boundary_hexamer_counter.sv =====
// channel   dir  tdata                                   tuser    tlast
// s_axis    in   base[2:0] region[4:3] strand[5]          action   -
//                hexamer[17:6], zero fill to 24 bits
// m_axis    out  count[31:0]                             -        -
// Each base transaction shifts the base into the history; from base 2*BOUNDARY+6
// of a gene on it also checks one interior window: skipped if it holds a non-ACGT
// base, else counted (read then write on the single table port, forward then reverse).
// A gene end of 60+ bases then flushes 2*(BOUNDARY-5) windows, each skipped or counted alike.
// A read loads its result into the output register; input stalls while a result waits there.
// After reset a clearing pass over all 24576 table entries zeroes the count table;
// no input is taken during it.
module boundary_hexamer_counter #(
    parameter int BOUNDARY    = bhc_pkg::BOUNDARY_DEF,
    parameter int COUNT_WIDTH = bhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // base[2:0] region[4:3] strand[5] hexamer[17:6]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // count[31:0]
);

    bhc_pkg::bhc_cmd_t cmd;
    bhc_pkg::bhc_sts_t sts;
    logic        out_load;
    logic [31:0] rd_count;
    logic        ovalid_reg;
    logic [31:0] odata_reg;

    bhc_ctrl #(.BOUNDARY(BOUNDARY)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_action(s_axis_tuser), .out_busy(ovalid_reg),
        .out_load(out_load), .cmd(cmd), .sts(sts)
    );

    bhc_dpath #(.BOUNDARY(BOUNDARY), .COUNT_WIDTH(COUNT_WIDTH)) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_base(s_axis_tdata[2:0]), .in_action(s_axis_tuser),
        .in_region(s_axis_tdata[4:3]), .in_strand(s_axis_tdata[5]),
        .in_hexamer(s_axis_tdata[17:6]), .rd_count(rd_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            odata_reg <= rd_count;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BND = bhc_pkg::BOUNDARY_DEF;
    localparam int WIN = bhc_pkg::WIN;
    localparam int MIN_GENE = 60;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  base;
        logic [1:0]  region;
        logic        strand;
        logic [11:0] hexamer;
    } hex_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    boundary_hexamer_counter uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] hist [0:6*4096-1];
    logic [31:0] totals [0:5];
    logic [2:0]  recent [0:BND+WIN-1];
    logic [2:0]  leading [0:BND-1];
    int          seen;

    hex_item_t   pending[$];
    logic [31:0] expected_counts[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          drain_wait = 0;
    bit          hold_sink = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // w[0] is the first base of the window
    task automatic count_hexamer(logic [2:0] w [0:5], int rgn);
        logic [11:0] fwd;
        logic [11:0] rev;
        fwd = '0;
        rev = '0;
        for (int j = 0; j < WIN; j++)
        begin
            if (w[j] > 3)
                return;
            fwd = {fwd[9:0], w[j][1:0]};
            rev = {rev[9:0], 2'd3 - w[WIN-1-j][1:0]};
        end
        hist[(rgn*2)*4096 + fwd] = sat_inc(hist[(rgn*2)*4096 + fwd]);
        hist[(rgn*2+1)*4096 + rev] = sat_inc(hist[(rgn*2+1)*4096 + rev]);
        totals[rgn*2] = sat_inc(totals[rgn*2]);
        totals[rgn*2+1] = sat_inc(totals[rgn*2+1]);
    endtask

    task automatic count_recent(int k, int rgn);
        logic [2:0] w [0:5];
        for (int j = 0; j < WIN; j++)
            w[j] = recent[k+WIN-1-j];
        count_hexamer(w, rgn);
    endtask

    task automatic predict_item(hex_item_t it);
        logic [2:0] w [0:5];
        int q;
        if (it.action == bhc_pkg::ACT_BASE || it.action == bhc_pkg::ACT_LAST)
        begin
            q = seen;
            for (int i = BND+WIN-1; i > 0; i--)
                recent[i] = recent[i-1];
            recent[0] = it.base;
            if (q < BND)
                leading[q] = it.base;
            if (q >= 2*BND+WIN-1)
                count_recent(BND, bhc_pkg::REG_INTERIOR);
            seen = (q < 127) ? q + 1 : 127;
            if (it.action == bhc_pkg::ACT_LAST)
            begin
                if (seen >= MIN_GENE)
                begin
                    for (int i = 0; i + WIN <= BND; i++)
                    begin
                        for (int j = 0; j < WIN; j++)
                            w[j] = leading[i+j];
                        count_hexamer(w, bhc_pkg::REG_START);
                    end
                    for (int i = 0; i + WIN <= BND; i++)
                        count_recent(i, bhc_pkg::REG_STOP);
                end
                seen = 0;
            end
        end
        else if (it.region > bhc_pkg::REG_INTERIOR)
            expected_counts = {expected_counts, 32'd0};
        else if (it.action == bhc_pkg::ACT_RDCNT)
            expected_counts = {expected_counts,
                               hist[(it.region*2+it.strand)*4096 + it.hexamer]};
        else
            expected_counts = {expected_counts, totals[it.region*2+it.strand]};
    endtask

    // driver
    int  src_gap = 0;
    bit  src_busy = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(pending.pop_front());
                src_gap = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0)
                    src_gap = 0;
                src_busy = 0;
            end
            if (!src_busy)
            begin
                if (src_gap > 0)
                    src_gap--;
                if (src_gap == 0 && pending.size() > 0 && !drain_wait)
                    src_busy = 1;
            end
            if (src_busy)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, pending[0].hexamer, pending[0].strand,
                                 pending[0].region, pending[0].base};
                s_axis_tuser <= pending[0].action;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor and sink
    int sink_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected transaction: count=%0h", m_axis_tdata);
                    errors++;
                end
                else if (expected_counts[0] !== m_axis_tdata)
                begin
                    $error("count: expected %0h actual %0h", expected_counts[0],
                           m_axis_tdata);
                    errors++;
                    void'(expected_counts.pop_front());
                end
                else
                    void'(expected_counts.pop_front());
                sink_gap = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0)
                    sink_gap = 0;
            end
            else if (sink_gap > 0)
                sink_gap--;
            m_axis_tready <= (sink_gap == 0) && !hold_sink;
        end
    end

    // long receiver hold-off
    initial
    begin
        wait (rst_n);
        repeat (25000) @(posedge clk);
        hold_sink = 1;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic hex_item_t mk(logic [1:0] a, logic [2:0] b);
        hex_item_t it;
        it.action = a;
        it.base = b;
        it.region = 2'($urandom_range(0, 3));
        it.strand = 1'($urandom_range(0, 1));
        it.hexamer = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    function automatic hex_item_t mk_read(logic [1:0] a, logic [1:0] r, logic s,
                                          logic [11:0] h);
        hex_item_t it;
        it.action = a;
        it.base = 3'($urandom_range(0, 7));
        it.region = r;
        it.strand = s;
        it.hexamer = h;
        return it;
    endfunction

    task automatic queue_gene(int len, int bad_pct, bit low_alpha);
        logic [2:0] b;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < bad_pct)
                b = 3'($urandom_range(4, 7));
            else if (low_alpha)
                b = 3'($urandom_range(0, 1));
            else
                b = 3'($urandom_range(0, 3));
            pending = {pending,
                       mk((i == len - 1) ? bhc_pkg::ACT_LAST : bhc_pkg::ACT_BASE, b)};
        end
    endtask

    task automatic queue_reads(int n);
        for (int i = 0; i < n; i++)
            pending = {pending, mk_read(2'($urandom_range(2, 3)), 2'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)),
                                        12'($urandom_range(0, 4095)))};
    endtask

    initial
    begin
        int count_items;
        bit paused;
        for (int i = 0; i < 6*4096; i++)
            hist[i] = '0;
        for (int i = 0; i < 6; i++)
            totals[i] = '0;
        for (int i = 0; i < BND+WIN; i++)
            recent[i] = bhc_pkg::BASE_INVALID;
        for (int i = 0; i < BND; i++)
            leading[i] = '0;
        seen = 0;
        paused = 0;

        // directed: reads of empty tables, region three, extremes
        pending = {pending, mk_read(bhc_pkg::ACT_RDCNT, bhc_pkg::REG_START, 1'b0, 12'h000)};
        pending = {pending, mk_read(bhc_pkg::ACT_RDCNT, bhc_pkg::REG_INTERIOR, 1'b1, 12'hFFF)};
        pending = {pending, mk_read(bhc_pkg::ACT_RDTOT, 2'd3, 1'b1, 12'hFFF)};
        pending = {pending, mk_read(bhc_pkg::ACT_RDCNT, 2'd3, 1'b0, 12'h000)};
        // short gene with non-ACGT base, then an all-A gene of exactly 60
        pending = {pending, mk(bhc_pkg::ACT_BASE, 3'd7)};
        pending = {pending, mk(bhc_pkg::ACT_BASE, 3'd3)};
        pending = {pending, mk(bhc_pkg::ACT_LAST, 3'd4)};
        for (int i = 0; i < MIN_GENE; i++)
            pending = {pending, mk((i == MIN_GENE-1) ? bhc_pkg::ACT_LAST : bhc_pkg::ACT_BASE,
                                   3'd0)};
        for (int r = 0; r < 3; r++)
            for (int s = 0; s < 2; s++)
                pending = {pending, mk_read(bhc_pkg::ACT_RDTOT, 2'(r), 1'(s), 12'h000)};
        pending = {pending, mk_read(bhc_pkg::ACT_RDCNT, bhc_pkg::REG_START, 1'b0, 12'h000)};
        pending = {pending, mk_read(bhc_pkg::ACT_RDCNT, bhc_pkg::REG_STOP, 1'b1, 12'hFFF)};

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        count_items = pending.size();
        while (count_items < 1250)
        begin
            int len;
            int nrd;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 59);
                1: len = $urandom_range(100, 140);
                default: len = $urandom_range(60, 80);
            endcase
            queue_gene(len, ($urandom_range(0, 2) == 0) ? 10 : 0, 1'($urandom_range(0, 1)));
            nrd = $urandom_range(2, 8);
            queue_reads(nrd);
            count_items += len + nrd;
            if (!paused && count_items > 600)
            begin
                // sender pause: wait for all results
                wait (pending.size() == 0);
                drain_wait = 1;
                wait (expected_counts.size() == 0);
                repeat (300) @(posedge clk);
                drain_wait = 0;
                paused = 1;
            end
        end
        // stretch of reads only to fill the output side
        queue_reads(60);
        wait (pending.size() == 0);
        wait (expected_counts.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_counts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/bhc_pkg.sv
hdl/bhc_ctrl.sv
hdl/bhc_dpath.sv
hdl/boundary_hexamer_counter.sv
verif/tb.sv
